// ===== sv/clt_pkg.sv =====
// ----------------------------------------------------------------------------
// clt_pkg: shared types and constants of the command line tokenizer
// Character codes, the one-hot tokenizer mode, the state record and the
// result record that travel between the step logic and the top level.
// ----------------------------------------------------------------------------
package clt_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DQ    = 8'h22;

    localparam logic       KIND_CHAR   = 1'b0;
    localparam logic       KIND_MARKER = 1'b1;

    localparam logic [1:0] REDIR_NONE   = 2'd0;
    localparam logic [1:0] REDIR_INPUT  = 2'd1;
    localparam logic [1:0] REDIR_OUTPUT = 2'd2;
    localparam logic [1:0] REDIR_APPEND = 2'd3;

    typedef enum logic [4:0] {
        MODE_LEAD  = 5'b00001,
        MODE_GT    = 5'b00010,
        MODE_REDIR = 5'b00100,
        MODE_WORD  = 5'b01000,
        MODE_QUOTE = 5'b10000
    } clt_mode_t;

    typedef struct packed {
        clt_mode_t  mode;
        logic       quote_is_double;
        logic [1:0] redirect_kind;
        logic       wild_seen;
        logic       word_nonempty;
    } clt_state_t;

    localparam clt_state_t STATE_RESET = '{
        mode:            MODE_LEAD,
        quote_is_double: 1'b0,
        redirect_kind:   REDIR_NONE,
        wild_seen:       1'b0,
        word_nonempty:   1'b0
    };

    typedef struct packed {
        logic       kind;
        logic [7:0] out_char;
        logic [1:0] redirect;
        logic       wild;
    } clt_result_t;

    typedef struct packed {
        logic        valid;
        clt_result_t res;
        clt_state_t  state;
    } clt_step_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

// ===== sv/command_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// command_line_tokenizer: byte-serial command line word splitter
// Splits a command line into word bytes and end-of-word markers that carry
// the redirection kind and the wildcard flag.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one command line byte per transfer in s_tdata; byte 0
//   ends the line and returns the tokenizer to its start state.
//   Master channel m_*: m_tuser is 0 for a word byte (m_tdata[7:0]) and 1 for
//   an end-of-word marker (redirect in m_tdata[9:8], wildcard in m_tdata[10]).
//   A byte gives zero or one result; a separator gives one only when it ends a
//   non-empty word, and opening or closing quotes and redirection marks outside a word give none.
//   Throughput: one byte per cycle while s_tready is high, that is while the skid entry is empty.
//   A result goes to the output entry, or to the skid entry if the output entry still holds one.
//   A two-entry output register pair (output plus skid) decouples the sides:
//   s_tready depends only on the skid entry, so bytes keep flowing while one
//   result waits; with the receiver stalled, s_tready drops once both
//   entries hold results and rises in the cycle after the receiver takes one.
//   Reset clears the tokenizer state and empties both output entries.
// ----------------------------------------------------------------------------
module command_line_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_char, [9:8] redirect, [10] wild
    output logic [0:0]  m_tuser    // [0] kind
);
    import clt_pkg::*;

    clt_state_t  state_reg, state_next;
    clt_step_t   step;
    clt_result_t out_reg, out_next;
    clt_result_t skid_reg, skid_next;
    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    logic        accept;
    logic        pop;
    logic        push;

    clt_step u_step (
        .state (state_reg),
        .ch    (s_tdata),
        .step  (step)
    );

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;
    assign push     = accept && step.valid;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {5'b0, out_reg.wild, out_reg.redirect, out_reg.out_char};

    always_comb
    begin
        state_next      = accept ? step.state : state_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_next       = step.res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = step.res;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= STATE_RESET;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the output entry is empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.kind == KIND_MARKER)) |-> (out_reg.out_char == 8'd0))
        else $error("end-of-word marker carries a character");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.kind == KIND_CHAR))
            |-> ((out_reg.redirect == REDIR_NONE) && !out_reg.wild))
        else $error("word character carries marker fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tdata == CH_NUL)) |=> (state_reg == STATE_RESET))
        else $error("end of line did not return the tokenizer to its start state");

endmodule

// ===== sv/clt_step.sv =====
// ----------------------------------------------------------------------------
// clt_step: next-state and result logic of the command line tokenizer
// Takes the current tokenizer state and one byte and gives the next state
// and at most one result, in a single combinational pass.
// ----------------------------------------------------------------------------
module clt_step (
    input  clt_pkg::clt_state_t state,
    input  logic [7:0]          ch,
    output clt_pkg::clt_step_t  step
);
    import clt_pkg::*;

    function automatic clt_step_t word_byte(input clt_state_t s, input logic [7:0] c);
        clt_step_t r;
        r       = '0;
        r.state = s;
        if ((c == CH_SQ) || (c == CH_DQ))
        begin
            r.state.quote_is_double = (c == CH_DQ);
            r.state.mode            = MODE_QUOTE;
        end
        else
        begin
            if ((c == CH_STAR) || (c == CH_QMARK))
                r.state.wild_seen = 1'b1;
            r.state.word_nonempty = 1'b1;
            r.valid               = 1'b1;
            r.res.kind            = KIND_CHAR;
            r.res.out_char        = c;
        end
        return r;
    endfunction

    function automatic clt_step_t start_word(input clt_state_t s, input logic [7:0] c);
        clt_state_t t;
        t                 = s;
        t.mode            = MODE_WORD;
        t.wild_seen       = 1'b0;
        t.word_nonempty   = 1'b0;
        t.quote_is_double = 1'b0;
        return word_byte(t, c);
    endfunction

    clt_result_t marker;
    logic        blank;

    assign blank = is_blank(ch);

    always_comb
    begin
        marker          = '0;
        marker.kind     = KIND_MARKER;
        marker.redirect = state.redirect_kind;
        marker.wild     = state.wild_seen;

        step       = '0;
        step.state = state;
        if (ch == CH_NUL)
        begin
            step.valid = ((state.mode == MODE_WORD) || (state.mode == MODE_QUOTE))
                         && state.word_nonempty;
            step.res   = marker;
            step.state = STATE_RESET;
        end
        else
        begin
            unique case (state.mode)
                MODE_GT:
                begin
                    if (ch == CH_GT)
                    begin
                        step.state.redirect_kind = REDIR_APPEND;
                        step.state.mode          = MODE_REDIR;
                    end
                    else if (blank)
                        step.state.mode = MODE_REDIR;
                    else
                        step = start_word(state, ch);
                end
                MODE_REDIR:
                begin
                    if (!blank)
                        step = start_word(state, ch);
                end
                MODE_WORD:
                begin
                    if (blank)
                    begin
                        step.valid = state.word_nonempty;
                        step.res   = marker;
                        step.state = STATE_RESET;
                    end
                    else
                        step = word_byte(state, ch);
                end
                MODE_QUOTE:
                begin
                    if (ch == (state.quote_is_double ? CH_DQ : CH_SQ))
                        step.state.mode = MODE_WORD;
                    else
                    begin
                        step.state.word_nonempty = 1'b1;
                        step.valid               = 1'b1;
                        step.res.kind            = KIND_CHAR;
                        step.res.out_char        = ch;
                    end
                end
                default:
                begin
                    if (blank)
                        step.state.mode = MODE_LEAD;
                    else if (ch == CH_LT)
                    begin
                        step.state.redirect_kind = REDIR_INPUT;
                        step.state.mode          = MODE_REDIR;
                    end
                    else if (ch == CH_GT)
                    begin
                        step.state.redirect_kind = REDIR_OUTPUT;
                        step.state.mode          = MODE_GT;
                    end
                    else
                    begin
                        step = start_word(state, ch);
                        step.state.redirect_kind = REDIR_NONE;
                    end
                end
            endcase
        end
    end

endmodule

// ===== dv/command_line_tokenizer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// command_line_tokenizer_tb: self-checking bench for the command line tokenizer
// Streams command line bytes into the slave channel and checks every word
// byte and end-of-word marker against a cycle-free model of the tokenizer.
// A short directed table covers redirections, quotes, wildcards and line
// ends. Random command lines with noise follow, and both sides stall in
// random bursts until the calm final stretch of the run.
// ----------------------------------------------------------------------------
module command_line_tokenizer_tb;

    import clt_pkg::*;

    localparam int          BYTE_COUNT = 1000;
    localparam int          CALM_FROM  = 850;
    localparam clt_result_t NO_RES     = '0;

    typedef struct packed {
        logic [7:0]  ch;
        logic        typed;
        logic        yields;
        clt_result_t res;
    } stim_row_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;

    logic        row_typed  = 1'b0;
    logic        row_yields = 1'b0;
    clt_result_t row_res    = '0;

    clt_mode_t   tk_mode     = MODE_LEAD;
    logic        tk_dquote   = 1'b0;
    logic [1:0]  tk_redir    = REDIR_NONE;
    logic        tk_wild     = 1'b0;
    logic        tk_nonempty = 1'b0;

    clt_result_t expected_tokens[$];
    logic [7:0]  line_bytes[$];
    int          mismatches = 0;
    bit          calm       = 1'b0;

    stim_row_t dir_rows [26] = '{
        '{CH_LT,    1'b1, 1'b0, NO_RES},
        '{CH_NUL,   1'b1, 1'b0, NO_RES},
        '{8'h61,    1'b1, 1'b1, '{KIND_CHAR,   8'h61, REDIR_NONE,   1'b0}},
        '{CH_SPACE, 1'b1, 1'b1, '{KIND_MARKER, 8'h00, REDIR_NONE,   1'b0}},
        '{CH_LT,    1'b1, 1'b0, NO_RES},
        '{8'hFF,    1'b1, 1'b1, '{KIND_CHAR,   8'hFF, REDIR_NONE,   1'b0}},
        '{CH_CR,    1'b1, 1'b1, '{KIND_MARKER, 8'h00, REDIR_INPUT,  1'b0}},
        '{CH_GT,    1'b1, 1'b0, NO_RES},
        '{CH_GT,    1'b1, 1'b0, NO_RES},
        '{CH_STAR,  1'b1, 1'b1, '{KIND_CHAR,   8'h2A, REDIR_NONE,   1'b0}},
        '{CH_TAB,   1'b1, 1'b1, '{KIND_MARKER, 8'h00, REDIR_APPEND, 1'b1}},
        '{CH_GT,    1'b1, 1'b0, NO_RES},
        '{CH_SPACE, 1'b1, 1'b0, NO_RES},
        '{CH_LT,    1'b0, 1'b0, NO_RES},
        '{CH_DQ,    1'b0, 1'b0, NO_RES},
        '{CH_SPACE, 1'b0, 1'b0, NO_RES},
        '{CH_SQ,    1'b0, 1'b0, NO_RES},
        '{CH_DQ,    1'b0, 1'b0, NO_RES},
        '{CH_QMARK, 1'b0, 1'b0, NO_RES},
        '{CH_NUL,   1'b0, 1'b0, NO_RES},
        '{CH_SQ,    1'b0, 1'b0, NO_RES},
        '{CH_SQ,    1'b0, 1'b0, NO_RES},
        '{8'h0A,    1'b0, 1'b0, NO_RES},
        '{CH_DQ,    1'b0, 1'b0, NO_RES},
        '{8'h80,    1'b0, 1'b0, NO_RES},
        '{CH_NUL,   1'b0, 1'b0, NO_RES}
    };

    command_line_tokenizer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("command_line_tokenizer_tb NOT OK");
        $finish;
    end

    function automatic bit is_sep(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic void clear_tokenizer();
        tk_mode     = MODE_LEAD;
        tk_dquote   = 1'b0;
        tk_redir    = REDIR_NONE;
        tk_wild     = 1'b0;
        tk_nonempty = 1'b0;
    endfunction

    function automatic bit take_word_byte(input logic [7:0] c, output clt_result_t r);
        r = '0;
        if (c == CH_SQ || c == CH_DQ)
        begin
            tk_dquote = (c == CH_DQ);
            tk_mode   = MODE_QUOTE;
            return 1'b0;
        end
        if (c == CH_STAR || c == CH_QMARK)
            tk_wild = 1'b1;
        tk_nonempty = 1'b1;
        r = '{KIND_CHAR, c, REDIR_NONE, 1'b0};
        return 1'b1;
    endfunction

    function automatic bit open_word(input logic [7:0] c, output clt_result_t r);
        tk_mode     = MODE_WORD;
        tk_wild     = 1'b0;
        tk_nonempty = 1'b0;
        tk_dquote   = 1'b0;
        return take_word_byte(c, r);
    endfunction

    function automatic bit tokenize_byte(input logic [7:0] c, output clt_result_t r);
        bit has;
        has = 1'b0;
        r   = '0;
        if (c == CH_NUL)
        begin
            if ((tk_mode == MODE_WORD || tk_mode == MODE_QUOTE) && tk_nonempty)
            begin
                r   = '{KIND_MARKER, 8'h00, tk_redir, tk_wild};
                has = 1'b1;
            end
            clear_tokenizer();
            return has;
        end
        case (tk_mode)
            MODE_GT:
            begin
                if (c == CH_GT)
                begin
                    tk_redir = REDIR_APPEND;
                    tk_mode  = MODE_REDIR;
                end
                else if (is_sep(c))
                    tk_mode = MODE_REDIR;
                else
                    has = open_word(c, r);
            end
            MODE_REDIR:
            begin
                if (!is_sep(c))
                    has = open_word(c, r);
            end
            MODE_WORD:
            begin
                if (is_sep(c))
                begin
                    if (tk_nonempty)
                    begin
                        r   = '{KIND_MARKER, 8'h00, tk_redir, tk_wild};
                        has = 1'b1;
                    end
                    clear_tokenizer();
                end
                else
                    has = take_word_byte(c, r);
            end
            MODE_QUOTE:
            begin
                if (c == (tk_dquote ? CH_DQ : CH_SQ))
                    tk_mode = MODE_WORD;
                else
                begin
                    tk_nonempty = 1'b1;
                    r   = '{KIND_CHAR, c, REDIR_NONE, 1'b0};
                    has = 1'b1;
                end
            end
            default:
            begin
                if (!is_sep(c))
                begin
                    if (c == CH_LT)
                    begin
                        tk_redir = REDIR_INPUT;
                        tk_mode  = MODE_REDIR;
                    end
                    else if (c == CH_GT)
                    begin
                        tk_redir = REDIR_OUTPUT;
                        tk_mode  = MODE_GT;
                    end
                    else
                    begin
                        tk_redir = REDIR_NONE;
                        has = open_word(c, r);
                    end
                end
            end
        endcase
        return has;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] seen);
        if (want !== seen)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        clt_result_t want;
        bit          has;
        if (!rst_n)
            clear_tokenizer();
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $error("unexpected result: tuser 0x%0h tdata 0x%0h", m_tuser, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    check_field("kind",      16'(want.kind),     16'(m_tuser[0]));
                    check_field("out_char",  16'(want.out_char), 16'(m_tdata[7:0]));
                    check_field("redirect",  16'(want.redirect), 16'(m_tdata[9:8]));
                    check_field("wild",      16'(want.wild),     16'(m_tdata[10]));
                    check_field("tdata pad", 16'd0,              16'(m_tdata[15:11]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                has = tokenize_byte(s_tdata, want);
                if (row_typed)
                begin
                    has  = row_yields;
                    want = row_res;
                end
                if (has)
                    expected_tokens.push_back(want);
            end
        end
    end

    initial
    begin : receiver
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    function automatic logic [7:0] blank_byte();
        if ($urandom_range(0, 3) == 0)
            return CH_SPACE;
        return 8'($urandom_range(CH_TAB, CH_CR));
    endfunction

    function automatic void build_line();
        logic [7:0] qc;
        logic [7:0] b;
        line_bytes.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(3, 16)) line_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(1, 5))
        begin
            repeat ($urandom_range(0, 2)) line_bytes.push_back(blank_byte());
            case ($urandom_range(0, 7))
                0: line_bytes.push_back(CH_LT);
                1: line_bytes.push_back(CH_GT);
                2:
                begin
                    line_bytes.push_back(CH_GT);
                    line_bytes.push_back(CH_GT);
                end
                3:
                begin
                    line_bytes.push_back(CH_GT);
                    line_bytes.push_back(CH_LT);
                end
                default: ;
            endcase
            repeat ($urandom_range(0, 1)) line_bytes.push_back(blank_byte());
            repeat ($urandom_range(0, 6))
            begin
                case ($urandom_range(0, 9))
                    0: line_bytes.push_back(CH_STAR);
                    1: line_bytes.push_back(CH_QMARK);
                    2, 3:
                    begin
                        qc = $urandom_range(0, 1) ? CH_DQ : CH_SQ;
                        line_bytes.push_back(qc);
                        repeat ($urandom_range(0, 4))
                        begin
                            b = 8'($urandom_range(1, 255));
                            line_bytes.push_back(b == qc ? CH_STAR : b);
                        end
                        if ($urandom_range(0, 7) != 0)
                            line_bytes.push_back(qc);
                    end
                    4: line_bytes.push_back(8'($urandom_range(128, 255)));
                    default: line_bytes.push_back(8'($urandom_range(33, 126)));
                endcase
            end
        end
        repeat ($urandom_range(0, 1)) line_bytes.push_back(blank_byte());
        line_bytes.push_back(CH_NUL);
    endfunction

    task automatic send_byte(input logic [7:0] ch, input logic typed, input logic yields,
                             input clt_result_t res);
        s_tvalid   <= 1'b1;
        s_tdata    <= ch;
        row_typed  <= typed;
        row_yields <= yields;
        row_res    <= res;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic idle_gap();
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (expected_tokens.size() != 0);
    endtask

    initial
    begin : stimulus
        int sent;
        sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            idle_gap();
            send_byte(dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].yields, dir_rows[i].res);
        end
        drain_results();

        while (sent < BYTE_COUNT)
        begin
            build_line();
            foreach (line_bytes[j])
            begin
                if (sent == BYTE_COUNT / 2)
                    drain_results();
                calm = (sent >= CALM_FROM);
                idle_gap();
                send_byte(line_bytes[j], 1'b0, 1'b0, NO_RES);
                sent++;
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_tokens.size() == 0)
            $display("command_line_tokenizer_tb OK");
        else
            $display("command_line_tokenizer_tb NOT OK");
        $finish;
    end

endmodule
